[hw/rtl/sacf_pkg.sv]
// Shared types and constants of the supervisor-aliased CSR file.
`default_nettype none
package sacf_pkg;

    localparam int unsigned CSR_AW = 12;
    localparam int unsigned CSR_DW = 64;

    // Access kinds.
    typedef enum logic [1:0] {
        K_READ       = 2'd0,
        K_WRITE      = 2'd1,
        K_FIELD_READ = 2'd2,
        K_FIELD_WRITE = 2'd3
    } t_kind;

    // CSR numbers with special handling.
    localparam logic [CSR_AW-1:0] ADDR_SSTATUS = 12'h100;
    localparam logic [CSR_AW-1:0] ADDR_SIE     = 12'h104;
    localparam logic [CSR_AW-1:0] ADDR_SIP     = 12'h144;
    localparam logic [CSR_AW-1:0] ADDR_MSTATUS = 12'h300;
    localparam logic [CSR_AW-1:0] ADDR_MISA    = 12'h301;
    localparam logic [CSR_AW-1:0] ADDR_MIDELEG = 12'h303;
    localparam logic [CSR_AW-1:0] ADDR_MIE     = 12'h304;
    localparam logic [CSR_AW-1:0] ADDR_MIP     = 12'h344;

    localparam logic [CSR_DW-1:0] MISA_RESET         = 64'h8000_0000_0014_112D;
    localparam logic [CSR_DW-1:0] SSTATUS_MASK_RESET = 64'h8000_0003_000D_E762;
    localparam logic [CSR_DW-1:0] UXL_FORCE          = 64'h0000_0002_0000_0000;
    localparam logic [CSR_DW-1:0] SSIP_BIT           = 64'h0000_0000_0000_0002;

    // Access sequencer states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Request from the access sequencer to the storage array.
    typedef struct packed {
        logic              rd_en;
        logic [CSR_AW-1:0] rd_addr;
        logic              wr_en;
        logic [CSR_AW-1:0] wr_addr;
        logic [CSR_DW-1:0] wr_data;
    } t_store_req;

endpackage
`default_nettype wire

[hw/rtl/sacf_store.sv]
// CSR storage array with its post-reset clearing pass.
`default_nettype none
module sacf_store (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sacf_pkg::t_store_req        i_req,
    output logic [sacf_pkg::CSR_DW-1:0]      o_rd_word,
    output logic [sacf_pkg::CSR_DW-1:0]      o_rd_deleg,
    output logic                             o_clearing
);
    import sacf_pkg::*;

    logic [CSR_DW-1:0] r_mem [0:(1<<CSR_AW)-1];
    logic              r_clearing;
    logic [CSR_AW-1:0] r_clr_addr;
    logic [CSR_DW-1:0] clr_data;

    // The clearing pass walks every entry once after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {CSR_AW{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Every entry clears to zero except misa.
    assign clr_data = (r_clr_addr == ADDR_MISA) ? MISA_RESET : '0;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= clr_data;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Two registered read ports: the addressed word and mideleg.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_word  <= r_mem[i_req.rd_addr];
            o_rd_deleg <= r_mem[ADDR_MIDELEG];
        end
    end

    assign o_clearing = r_clearing;

endmodule
`default_nettype wire

[hw/rtl/supervisor_aliased_csr_file_top.sv]
// Top level of the supervisor-aliased RV64 CSR file.
//
// On acceptance the target word and mideleg are read from the storage array into
// registers; in the execute state the access writes back and registers the
// result, which shows on o_read_data with o_done high for exactly one cycle. The
// receiver cannot stall, and busy is high while an access is in flight, so a new
// start is not taken while an access executes. After reset the array is swept once,
// one entry per cycle, and busy stays high until the sweep is done, so no access is
// taken before it ends; configuration writes are taken at any time.
`default_nettype none
module supervisor_aliased_csr_file_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sacf_pkg::CSR_DW-1:0]   i_cfg_wdata,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [sacf_pkg::CSR_AW-1:0]   i_csr_address,
    input  wire logic [sacf_pkg::CSR_DW-1:0]   i_write_value,
    input  wire logic [5:0]                    i_field_high,
    input  wire logic [5:0]                    i_field_low,
    output logic                               o_done,
    output logic [sacf_pkg::CSR_DW-1:0]        o_read_data
);
    import sacf_pkg::*;

    t_state            r_state, n_state;
    logic [CSR_DW-1:0] r_sstatus_mask;
    t_kind             r_kind;
    logic [CSR_AW-1:0] r_addr;
    logic [CSR_AW-1:0] r_phys;
    logic [CSR_DW-1:0] r_wval;
    logic [5:0]        r_hi;
    logic [5:0]        r_lo;
    logic [CSR_DW-1:0] n_read_data;
    logic              n_done;

    t_store_req        store_req;
    logic [CSR_DW-1:0] rd_word;
    logic [CSR_DW-1:0] rd_deleg;
    logic              clearing;
    logic              accept;
    logic [CSR_AW-1:0] phys_addr;
    logic [CSR_DW-1:0] fmask;
    logic              field_ok;
    logic [CSR_DW-1:0] alias_mask;
    logic [CSR_DW-1:0] wb_data;
    logic              wb_en;

    sacf_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .o_rd_word  (rd_word),
        .o_rd_deleg (rd_deleg),
        .o_clearing (clearing)
    );

    assign busy   = clearing || (r_state == S_EXEC);
    assign accept = start && !busy;

    // Supervisor views of plain accesses map onto their machine registers.
    always_comb begin
        phys_addr = i_csr_address;
        if (i_kind == K_READ || i_kind == K_WRITE) begin
            case (i_csr_address)
                ADDR_SSTATUS: phys_addr = ADDR_MSTATUS;
                ADDR_SIE:     phys_addr = ADDR_MIE;
                ADDR_SIP:     phys_addr = ADDR_MIP;
                default:      phys_addr = i_csr_address;
            endcase
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sstatus_mask <= SSTATUS_MASK_RESET;
        end else if (i_cfg_we) begin
            r_sstatus_mask <= i_cfg_wdata;
        end
    end

    // Capture the access on its transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= t_kind'(i_kind);
            r_addr <= i_csr_address;
            r_phys <= phys_addr;
            r_wval <= i_write_value;
            r_hi   <= i_field_high;
            r_lo   <= i_field_low;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Field mask spanning bits r_lo through r_hi.
    assign field_ok = (r_hi >= r_lo);
    assign fmask    = ({CSR_DW{1'b1}} >> (6'd63 - r_hi)) & ({CSR_DW{1'b1}} << r_lo);

    // Bits that a plain write may change in the underlying register.
    always_comb begin
        case (r_addr)
            ADDR_SSTATUS: alias_mask = r_sstatus_mask;
            ADDR_SIE:     alias_mask = rd_deleg;
            ADDR_SIP:     alias_mask = rd_deleg & SSIP_BIT;
            default:      alias_mask = {CSR_DW{1'b1}};
        endcase
    end

    // Result and write-back of the access in flight.
    always_comb begin
        n_done      = (r_state == S_EXEC);
        n_read_data = '0;
        wb_en       = 1'b0;
        wb_data     = rd_word;
        if (r_state == S_EXEC) begin
            case (r_kind)
                K_READ: begin
                    case (r_addr)
                        ADDR_SSTATUS: n_read_data = rd_word & r_sstatus_mask;
                        ADDR_SIE:     n_read_data = rd_word & rd_deleg;
                        ADDR_SIP:     n_read_data = rd_word & rd_deleg;
                        ADDR_MSTATUS: n_read_data = rd_word | UXL_FORCE;
                        default:      n_read_data = rd_word;
                    endcase
                end
                K_WRITE: begin
                    wb_en   = 1'b1;
                    wb_data = (rd_word & ~alias_mask) | (r_wval & alias_mask);
                end
                K_FIELD_READ: begin
                    if (field_ok) begin
                        n_read_data = (rd_word & fmask) >> r_lo;
                    end
                end
                K_FIELD_WRITE: begin
                    wb_en   = field_ok;
                    wb_data = (rd_word & ~fmask) | ((r_wval << r_lo) & fmask);
                end
                default: begin
                    n_read_data = '0;
                end
            endcase
        end
    end

    // Storage request: read on transfer, write back at the end of the access.
    always_comb begin
        store_req.rd_en   = accept;
        store_req.rd_addr = phys_addr;
        store_req.wr_en   = wb_en;
        store_req.wr_addr = r_phys;
        store_req.wr_data = wb_data;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_done) begin
            o_read_data <= n_read_data;
        end
    end

    // A result follows only an access that was executing.
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without an executing access");

    // An accepted access executes in the next cycle.
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted access did not execute");

    // Write-back happens only while an access executes and never during clearing.
    a_wb_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wb_en |-> (r_state == S_EXEC && !clearing))
        else $error("write-back outside an executing access");

    // No access is taken while the array is being cleared.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (!accept && r_state == S_IDLE))
        else $error("access taken during clearing pass");

endmodule
`default_nettype wire
